// File: rtl/core/bas_pkg.sv
// shared types, constants and helpers of the ballistic aim solver
package bas_pkg;

  // fixed point format and register reset (9.8 rounded to nearest)
  localparam int unsigned FRAC_BITS     = 16;
  localparam int unsigned GRAVITY_RESET = ((49 << FRAC_BITS) + 2) / 5;

  // chain lengths and normalised width
  localparam int unsigned SQRT_CELLS = 64;
  localparam int unsigned DIV_CELLS  = 31;
  localparam int unsigned NORM_BITS  = 62;

  // request and result payloads
  typedef struct packed {
    logic signed [31:0] start_x;
    logic signed [31:0] start_y;
    logic signed [31:0] start_z;
    logic signed [31:0] target_x;
    logic signed [31:0] target_y;
    logic signed [31:0] target_z;
    logic        [30:0] launch_speed;
  } in_req_t;

  typedef struct packed {
    logic signed [31:0] vel_x;
    logic signed [31:0] vel_y;
    logic signed [31:0] vel_z;
    logic               reachable;
  } out_rsp_t;

  // one square root digit lane
  typedef struct packed {
    logic [127:0] n;
    logic [65:0]  rem;
    logic [63:0]  root;
  } sqrt_lane_t;

  // sideband travelling with a square root lane
  typedef struct packed {
    logic        v;
    logic        ok;
    logic        negx;
    logic        negy;
    logic        negz;
    logic [30:0] s;
    logic [63:0] a;
    logic [63:0] b;
    logic [63:0] c;
  } side_t;

  // one divider lane
  typedef struct packed {
    logic [63:0] rem;
    logic [30:0] nlo;
    logic [30:0] q;
  } div_lane_t;

  // divider cell contents: x, y and z lanes share the divisor
  typedef struct packed {
    logic                v;
    logic                ok;
    logic                negx;
    logic                negy;
    logic                negz;
    logic [63:0]         d;
    div_lane_t [2:0]     lane;
  } div_t;

  // position of the leading one plus one, zero for zero
  function automatic logic [6:0] bitlen64(input logic [63:0] v);
    logic [6:0] n;
    n = '0;
    for (int i = 0; i < 64; i++) begin
      if (v[i]) n = 7'(i + 1);
    end
    return n;
  endfunction

endpackage

// File: rtl/core/bas_in_if.sv
// request channel of the aim solver
interface bas_in_if;
  logic            valid;
  logic            ready;
  bas_pkg::in_req_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// File: rtl/core/bas_out_if.sv
// result channel of the aim solver
interface bas_out_if;
  logic             valid;
  logic             ready;
  bas_pkg::out_rsp_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// File: rtl/core/bas_mul.sv
// two stage 64 by 64 multiplier built from 32 by 32 partial products
module bas_mul (
  input  logic         clk_i,
  input  logic         en_i,
  input  logic [63:0]  a_i,
  input  logic [63:0]  b_i,
  output logic [127:0] p_o
);

  logic [63:0]  pp00_q, pp01_q, pp10_q, pp11_q;
  logic [127:0] p_q;

  // partial products
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      pp00_q <= a_i[31:0]  * b_i[31:0];
      pp01_q <= a_i[31:0]  * b_i[63:32];
      pp10_q <= a_i[63:32] * b_i[31:0];
      pp11_q <= a_i[63:32] * b_i[63:32];
    end
  end

  // recombine
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      p_q <= {64'b0, pp00_q} + {32'b0, pp01_q, 32'b0} + {32'b0, pp10_q, 32'b0}
           + {pp11_q, 64'b0};
    end
  end

  assign p_o = p_q;

endmodule

// File: rtl/core/bas_sqrt_cell.sv
// one digit of a pipelined integer square root, two radicand bits per cell
module bas_sqrt_cell (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                en_i,
  input  bas_pkg::sqrt_lane_t lane_i,
  input  bas_pkg::side_t      side_i,
  output bas_pkg::sqrt_lane_t lane_o,
  output bas_pkg::side_t      side_o
);

  bas_pkg::sqrt_lane_t lane_d, lane_q;
  bas_pkg::side_t      side_q;
  logic                v_q;
  logic [67:0]         shl, trial, diff;
  logic                ge;

  // bring down two bits and try the next root digit
  always_comb begin
    shl         = {lane_i.rem, lane_i.n[127:126]};
    trial       = {2'b00, lane_i.root, 2'b01};
    diff        = shl - trial;
    ge          = (shl >= trial);
    lane_d.n    = {lane_i.n[125:0], 2'b00};
    lane_d.rem  = ge ? diff[65:0] : shl[65:0];
    lane_d.root = {lane_i.root[62:0], ge};
  end

  // valid flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= 1'b0;
    end else if (en_i) begin
      v_q <= side_i.v;
    end
  end

  // payload
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      lane_q <= lane_d;
      side_q <= side_i;
    end
  end

  always_comb begin
    side_o   = side_q;
    side_o.v = v_q;
  end
  assign lane_o = lane_q;

endmodule

// File: rtl/core/bas_div_cell.sv
// one quotient bit of three restoring divisions sharing a divisor
module bas_div_cell (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          en_i,
  input  bas_pkg::div_t div_i,
  output bas_pkg::div_t div_o
);

  bas_pkg::div_t div_d, div_q;
  logic          v_q;
  logic [64:0]   t   [3];
  logic [64:0]   dif [3];
  logic          ge  [3];

  // shift in the next numerator bit and subtract where it fits
  always_comb begin
    div_d = div_i;
    for (int k = 0; k < 3; k++) begin
      t[k]   = {div_i.lane[k].rem, div_i.lane[k].nlo[30]};
      dif[k] = t[k] - {1'b0, div_i.d};
      ge[k]  = (t[k] >= {1'b0, div_i.d});
      div_d.lane[k].rem = ge[k] ? dif[k][63:0] : t[k][63:0];
      div_d.lane[k].nlo = {div_i.lane[k].nlo[29:0], 1'b0};
      div_d.lane[k].q   = {div_i.lane[k].q[29:0], ge[k]};
    end
  end

  // valid flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= 1'b0;
    end else if (en_i) begin
      v_q <= div_i.v;
    end
  end

  // payload
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      div_q <= div_d;
    end
  end

  always_comb begin
    div_o   = div_q;
    div_o.v = v_q;
  end

endmodule

// File: rtl/core/ballistic_aim_solver.sv
// ballistic aim solver top level: fully pipelined launch velocity solver
//
//  channel      dir  handshake        payload
//  aim_req_i    in   valid / ready    start, target points, launch speed
//  aim_rsp_o    out  valid / ready    velocity vector, reachable flag
//  gravity_*    in   write enable     gravity register, 31 bits
//
// one request per cycle while the result is not stalled; each result passes
// through the two 64 cell square root chains and the 31 cell divider chain.
// reset clears every valid flag and loads gravity with 9.8.
// a stalled result freezes the whole pipeline; a new request is taken
// whenever the output register is empty or being emptied.
module ballistic_aim_solver (
  input  logic        clk_i,
  input  logic        rst_ni,
  bas_in_if.sink      aim_req_i,
  bas_out_if.source   aim_rsp_o,
  input  logic        gravity_we_i,
  input  logic [30:0] gravity_i
);

  logic en;
  logic [30:0] gravity_q;

  // gravity register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gravity_q <= bas_pkg::GRAVITY_RESET[30:0];
    end else if (gravity_we_i) begin
      gravity_q <= gravity_i;
    end
  end

  // input differences
  logic signed [32:0] dx_c, dy_c, dz_c;
  assign dx_c = {aim_req_i.data.target_x[31], aim_req_i.data.target_x}
              - {aim_req_i.data.start_x[31], aim_req_i.data.start_x};
  assign dy_c = {aim_req_i.data.target_y[31], aim_req_i.data.target_y}
              - {aim_req_i.data.start_y[31], aim_req_i.data.start_y};
  assign dz_c = {aim_req_i.data.target_z[31], aim_req_i.data.target_z}
              - {aim_req_i.data.start_z[31], aim_req_i.data.start_z};

  function automatic logic [32:0] abs33(input logic signed [32:0] v);
    return v[32] ? 33'(-v) : 33'(v);
  endfunction

  // valid flags of the non cell stages
  logic v0_q, v1_q, v2_q, v3_q, v4_q, v5_q, v6_q;
  logic p1v_q, p2v_q, p3v_q, p4v_q, q1v_q, q2v_q, hv_q, n1v_q, n2v_q, dv_v_q;
  logic rsp_valid_q;

  // stage 0: request register
  logic        ok0_q, nx0_q, ny0_q, nz0_q;
  logic [32:0] mx0_q, my0_q, mz0_q;
  logic [30:0] s0_q, g0_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      mx0_q <= abs33(dx_c);
      my0_q <= abs33(dy_c);
      mz0_q <= abs33(dz_c);
      nx0_q <= dx_c[32];
      ny0_q <= dy_c[32];
      nz0_q <= dz_c[32];
      s0_q  <= aim_req_i.data.launch_speed;
      g0_q  <= gravity_q;
      ok0_q <= (gravity_q != '0) && ((dx_c != '0) || (dz_c != '0));
    end
  end

  // first products: g*|dx|, g*|dz|, g*|dy|, s*s
  logic [127:0] p_cx, p_cz, p_gy, p_s2;
  bas_mul u_m_cx (.clk_i, .en_i(en), .a_i({33'b0, g0_q}), .b_i({31'b0, mx0_q}), .p_o(p_cx));
  bas_mul u_m_cz (.clk_i, .en_i(en), .a_i({33'b0, g0_q}), .b_i({31'b0, mz0_q}), .p_o(p_cz));
  bas_mul u_m_gy (.clk_i, .en_i(en), .a_i({33'b0, g0_q}), .b_i({31'b0, my0_q}), .p_o(p_gy));
  bas_mul u_m_s2 (.clk_i, .en_i(en), .a_i({33'b0, s0_q}), .b_i({33'b0, s0_q}), .p_o(p_s2));

  // sideband over the first products
  logic        ok1_q, nx1_q, ny1_q, nz1_q, ok2_q, nx2_q, ny2_q, nz2_q;
  logic [30:0] s1_q, s2s_q;
  always_ff @(posedge clk_i) begin
    if (en) begin
      {ok1_q, nx1_q, ny1_q, nz1_q, s1_q}  <= {ok0_q, nx0_q, ny0_q, nz0_q, s0_q};
      {ok2_q, nx2_q, ny2_q, nz2_q, s2s_q} <= {ok1_q, nx1_q, ny1_q, nz1_q, s1_q};
    end
  end

  logic [63:0] cx2, cz2, gy2, sq2;
  assign cx2 = p_cx[63:0];
  assign cz2 = p_cz[63:0];
  assign gy2 = p_gy[63:0];
  assign sq2 = p_s2[63:0];

  // second products: s^4, cx^2, cz^2, g*|dy|*s^2
  logic [127:0] p_a, p_bx, p_bz, p_c;
  bas_mul u_m_a  (.clk_i, .en_i(en), .a_i(sq2), .b_i(sq2), .p_o(p_a));
  bas_mul u_m_bx (.clk_i, .en_i(en), .a_i(cx2), .b_i(cx2), .p_o(p_bx));
  bas_mul u_m_bz (.clk_i, .en_i(en), .a_i(cz2), .b_i(cz2), .p_o(p_bz));
  bas_mul u_m_c  (.clk_i, .en_i(en), .a_i(gy2), .b_i(sq2), .p_o(p_c));

  // sideband over the second products
  logic        ok3_q, nx3_q, ny3_q, nz3_q, ok4_q, nx4_q, ny4_q, nz4_q;
  logic [30:0] s3_q, s4_q;
  logic [63:0] cx3_q, cz3_q, sq3_q, cx4_q, cz4_q, sq4_q;
  always_ff @(posedge clk_i) begin
    if (en) begin
      {ok3_q, nx3_q, ny3_q, nz3_q, s3_q} <= {ok2_q, nx2_q, ny2_q, nz2_q, s2s_q};
      {ok4_q, nx4_q, ny4_q, nz4_q, s4_q} <= {ok3_q, nx3_q, ny3_q, nz3_q, s3_q};
      {cx3_q, cz3_q, sq3_q} <= {cx2, cz2, sq2};
      {cx4_q, cz4_q, sq4_q} <= {cx3_q, cz3_q, sq3_q};
    end
  end

  // stage 5: B = cx^2 + cz^2, C doubled
  logic         ok5_q, nx5_q, ny5_q, nz5_q;
  logic [30:0]  s5_q;
  logic [63:0]  cx5_q, cz5_q, sq5_q;
  logic [127:0] a5_q, b5_q, c5_q;
  always_ff @(posedge clk_i) begin
    if (en) begin
      {ok5_q, nx5_q, ny5_q, nz5_q, s5_q} <= {ok4_q, nx4_q, ny4_q, nz4_q, s4_q};
      {cx5_q, cz5_q, sq5_q} <= {cx4_q, cz4_q, sq4_q};
      a5_q <= p_a;
      b5_q <= p_bx + p_bz;
      c5_q <= {p_c[126:0], 1'b0};
    end
  end

  // stage 6: discriminant and its sign test
  logic [127:0] sum6, d6;
  logic         fail6;
  always_comb begin
    if (!ny5_q) begin
      sum6  = b5_q + c5_q;
      fail6 = (a5_q < sum6);
      d6    = a5_q - sum6;
    end else begin
      sum6  = a5_q + c5_q;
      fail6 = (sum6 < b5_q);
      d6    = sum6 - b5_q;
    end
  end

  logic         ok6_q, nx6_q, ny6_q, nz6_q;
  logic [30:0]  s6_q;
  logic [63:0]  cx6_q, cz6_q, sq6_q;
  logic [127:0] d6_q;
  always_ff @(posedge clk_i) begin
    if (en) begin
      ok6_q <= ok5_q && !fail6;
      {nx6_q, ny6_q, nz6_q, s6_q} <= {nx5_q, ny5_q, nz5_q, s5_q};
      {cx6_q, cz6_q, sq6_q} <= {cx5_q, cz5_q, sq5_q};
      d6_q  <= d6;
    end
  end

  // square root chain of the discriminant
  bas_pkg::sqrt_lane_t sq1_lane [bas_pkg::SQRT_CELLS+1];
  bas_pkg::side_t      sq1_side [bas_pkg::SQRT_CELLS+1];

  always_comb begin
    sq1_lane[0].n    = d6_q;
    sq1_lane[0].rem  = '0;
    sq1_lane[0].root = '0;
    sq1_side[0].v    = v6_q;
    sq1_side[0].ok   = ok6_q;
    sq1_side[0].negx = nx6_q;
    sq1_side[0].negy = ny6_q;
    sq1_side[0].negz = nz6_q;
    sq1_side[0].s    = s6_q;
    sq1_side[0].a    = sq6_q;
    sq1_side[0].b    = cx6_q;
    sq1_side[0].c    = cz6_q;
  end

  for (genvar i = 0; i < bas_pkg::SQRT_CELLS; i++) begin : g_sq1
    bas_sqrt_cell u_cell (
      .clk_i, .rst_ni, .en_i(en),
      .lane_i(sq1_lane[i]), .side_i(sq1_side[i]),
      .lane_o(sq1_lane[i+1]), .side_o(sq1_side[i+1])
    );
  end

  bas_pkg::side_t sq1_end;
  logic [63:0]    r_root;
  assign sq1_end = sq1_side[bas_pkg::SQRT_CELLS];
  assign r_root  = sq1_lane[bas_pkg::SQRT_CELLS].root;

  // p1: vertical component s^2 - sqrt(D) and its sign
  logic        pok1_q, pnx1_q, pny1_q, pnz1_q;
  logic [30:0] ps1_q;
  logic [63:0] pcx1_q, pcy1_q, pcz1_q;
  always_ff @(posedge clk_i) begin
    if (en) begin
      {pok1_q, pnx1_q, pnz1_q, ps1_q} <= {sq1_end.ok, sq1_end.negx, sq1_end.negz, sq1_end.s};
      pny1_q <= (r_root > sq1_end.a);
      pcy1_q <= (r_root > sq1_end.a) ? r_root - sq1_end.a : sq1_end.a - r_root;
      pcx1_q <= sq1_end.b;
      pcz1_q <= sq1_end.c;
    end
  end

  // p2: largest magnitude
  logic        pok2_q, pnx2_q, pny2_q, pnz2_q;
  logic [30:0] ps2_q;
  logic [63:0] pcx2_q, pcy2_q, pcz2_q, pm2_q, m_c;
  always_comb begin
    m_c = (pcx1_q > pcy1_q) ? pcx1_q : pcy1_q;
    if (pcz1_q > m_c) m_c = pcz1_q;
  end
  always_ff @(posedge clk_i) begin
    if (en) begin
      {pok2_q, pnx2_q, pny2_q, pnz2_q, ps2_q} <= {pok1_q, pnx1_q, pny1_q, pnz1_q, ps1_q};
      {pcx2_q, pcy2_q, pcz2_q} <= {pcx1_q, pcy1_q, pcz1_q};
      pm2_q <= m_c;
    end
  end

  // p3: bit length of the largest
  logic        pok3_q, pnx3_q, pny3_q, pnz3_q;
  logic [30:0] ps3_q;
  logic [63:0] pcx3_q, pcy3_q, pcz3_q;
  logic [6:0]  pbl3_q;
  always_ff @(posedge clk_i) begin
    if (en) begin
      {pok3_q, pnx3_q, pny3_q, pnz3_q, ps3_q} <= {pok2_q, pnx2_q, pny2_q, pnz2_q, ps2_q};
      {pcx3_q, pcy3_q, pcz3_q} <= {pcx2_q, pcy2_q, pcz2_q};
      pbl3_q <= bas_pkg::bitlen64(pm2_q);
    end
  end

  // p4: common shift to the normalised width
  logic [6:0]  amt;
  logic [63:0] ncx, ncy, ncz;
  always_comb begin
    if (pbl3_q > 7'(bas_pkg::NORM_BITS)) begin
      amt = pbl3_q - 7'(bas_pkg::NORM_BITS);
      ncx = pcx3_q >> amt;
      ncy = pcy3_q >> amt;
      ncz = pcz3_q >> amt;
    end else begin
      amt = 7'(bas_pkg::NORM_BITS) - pbl3_q;
      ncx = pcx3_q << amt;
      ncy = pcy3_q << amt;
      ncz = pcz3_q << amt;
    end
  end

  logic        pok4_q, pnx4_q, pny4_q, pnz4_q;
  logic [30:0] ps4_q;
  logic [63:0] pcx4_q, pcy4_q, pcz4_q;
  always_ff @(posedge clk_i) begin
    if (en) begin
      {pok4_q, pnx4_q, pny4_q, pnz4_q, ps4_q} <= {pok3_q, pnx3_q, pny3_q, pnz3_q, ps3_q};
      {pcx4_q, pcy4_q, pcz4_q} <= {ncx, ncy, ncz};
    end
  end

  // squares of the normalised components
  logic [127:0] p_qx, p_qy, p_qz;
  bas_mul u_m_qx (.clk_i, .en_i(en), .a_i(pcx4_q), .b_i(pcx4_q), .p_o(p_qx));
  bas_mul u_m_qy (.clk_i, .en_i(en), .a_i(pcy4_q), .b_i(pcy4_q), .p_o(p_qy));
  bas_mul u_m_qz (.clk_i, .en_i(en), .a_i(pcz4_q), .b_i(pcz4_q), .p_o(p_qz));

  logic        qok1_q, qnx1_q, qny1_q, qnz1_q, qok2_q, qnx2_q, qny2_q, qnz2_q;
  logic [30:0] qs1_q, qs2_q;
  logic [63:0] qcx1_q, qcy1_q, qcz1_q, qcx2_q, qcy2_q, qcz2_q;
  always_ff @(posedge clk_i) begin
    if (en) begin
      {qok1_q, qnx1_q, qny1_q, qnz1_q, qs1_q} <= {pok4_q, pnx4_q, pny4_q, pnz4_q, ps4_q};
      {qok2_q, qnx2_q, qny2_q, qnz2_q, qs2_q} <= {qok1_q, qnx1_q, qny1_q, qnz1_q, qs1_q};
      {qcx1_q, qcy1_q, qcz1_q} <= {pcx4_q, pcy4_q, pcz4_q};
      {qcx2_q, qcy2_q, qcz2_q} <= {qcx1_q, qcy1_q, qcz1_q};
    end
  end

  // sum of squares
  logic         hok_q, hnx_q, hny_q, hnz_q;
  logic [30:0]  hs_q;
  logic [63:0]  hcx_q, hcy_q, hcz_q;
  logic [127:0] hsum_q;
  always_ff @(posedge clk_i) begin
    if (en) begin
      {hok_q, hnx_q, hny_q, hnz_q, hs_q} <= {qok2_q, qnx2_q, qny2_q, qnz2_q, qs2_q};
      {hcx_q, hcy_q, hcz_q} <= {qcx2_q, qcy2_q, qcz2_q};
      hsum_q <= p_qx + p_qy + p_qz;
    end
  end

  // square root chain of the vector length
  bas_pkg::sqrt_lane_t sq2_lane [bas_pkg::SQRT_CELLS+1];
  bas_pkg::side_t      sq2_side [bas_pkg::SQRT_CELLS+1];

  always_comb begin
    sq2_lane[0].n    = hsum_q;
    sq2_lane[0].rem  = '0;
    sq2_lane[0].root = '0;
    sq2_side[0].v    = hv_q;
    sq2_side[0].ok   = hok_q;
    sq2_side[0].negx = hnx_q;
    sq2_side[0].negy = hny_q;
    sq2_side[0].negz = hnz_q;
    sq2_side[0].s    = hs_q;
    sq2_side[0].a    = hcy_q;
    sq2_side[0].b    = hcx_q;
    sq2_side[0].c    = hcz_q;
  end

  for (genvar i = 0; i < bas_pkg::SQRT_CELLS; i++) begin : g_sq2
    bas_sqrt_cell u_cell (
      .clk_i, .rst_ni, .en_i(en),
      .lane_i(sq2_lane[i]), .side_i(sq2_side[i]),
      .lane_o(sq2_lane[i+1]), .side_o(sq2_side[i+1])
    );
  end

  bas_pkg::side_t sq2_end;
  logic [63:0]    len;
  assign sq2_end = sq2_side[bas_pkg::SQRT_CELLS];
  assign len     = sq2_lane[bas_pkg::SQRT_CELLS].root;

  // numerators s * component
  logic [127:0] p_nx, p_ny, p_nz;
  bas_mul u_m_nx (.clk_i, .en_i(en), .a_i({33'b0, sq2_end.s}), .b_i(sq2_end.b), .p_o(p_nx));
  bas_mul u_m_ny (.clk_i, .en_i(en), .a_i({33'b0, sq2_end.s}), .b_i(sq2_end.a), .p_o(p_ny));
  bas_mul u_m_nz (.clk_i, .en_i(en), .a_i({33'b0, sq2_end.s}), .b_i(sq2_end.c), .p_o(p_nz));

  logic        nok1_q, nnx1_q, nny1_q, nnz1_q, nok2_q, nnx2_q, nny2_q, nnz2_q;
  logic [63:0] nl1_q, nl2_q;
  always_ff @(posedge clk_i) begin
    if (en) begin
      {nok1_q, nnx1_q, nny1_q, nnz1_q, nl1_q} <=
        {sq2_end.ok, sq2_end.negx, sq2_end.negy, sq2_end.negz, len};
      {nok2_q, nnx2_q, nny2_q, nnz2_q, nl2_q} <= {nok1_q, nnx1_q, nny1_q, nnz1_q, nl1_q};
    end
  end

  // rounding half added, divider chain loaded
  logic [127:0]  hn [3];
  bas_pkg::div_t dv_q;
  always_comb begin
    hn[0] = p_nx + {65'b0, nl2_q[63:1]};
    hn[1] = p_ny + {65'b0, nl2_q[63:1]};
    hn[2] = p_nz + {65'b0, nl2_q[63:1]};
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      dv_q.v    <= n2v_q;
      dv_q.ok   <= nok2_q;
      dv_q.negx <= nnx2_q;
      dv_q.negy <= nny2_q;
      dv_q.negz <= nnz2_q;
      dv_q.d    <= nl2_q;
      for (int k = 0; k < 3; k++) begin
        dv_q.lane[k].rem <= hn[k][94:31];
        dv_q.lane[k].nlo <= hn[k][30:0];
        dv_q.lane[k].q   <= '0;
      end
    end
  end

  // divider chain input takes the reset valid flag
  bas_pkg::div_t div_c [bas_pkg::DIV_CELLS+1];
  always_comb begin
    div_c[0]   = dv_q;
    div_c[0].v = dv_v_q;
  end

  for (genvar i = 0; i < bas_pkg::DIV_CELLS; i++) begin : g_div
    bas_div_cell u_cell (.clk_i, .rst_ni, .en_i(en), .div_i(div_c[i]), .div_o(div_c[i+1]));
  end

  bas_pkg::div_t div_end;
  assign div_end = div_c[bas_pkg::DIV_CELLS];

  // output register with sign restore
  bas_pkg::out_rsp_t rsp_d, rsp_q;
  always_comb begin
    rsp_d.reachable = div_end.ok;
    rsp_d.vel_x = '0;
    rsp_d.vel_y = '0;
    rsp_d.vel_z = '0;
    if (div_end.ok) begin
      rsp_d.vel_x = div_end.negx ? -$signed({1'b0, div_end.lane[0].q})
                                 : $signed({1'b0, div_end.lane[0].q});
      rsp_d.vel_y = div_end.negy ? -$signed({1'b0, div_end.lane[1].q})
                                 : $signed({1'b0, div_end.lane[1].q});
      rsp_d.vel_z = div_end.negz ? -$signed({1'b0, div_end.lane[2].q})
                                 : $signed({1'b0, div_end.lane[2].q});
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      rsp_q <= rsp_d;
    end
  end

  // valid flags of the plain stages
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      {v0_q, v1_q, v2_q, v3_q, v4_q, v5_q, v6_q} <= '0;
      {p1v_q, p2v_q, p3v_q, p4v_q, q1v_q, q2v_q, hv_q} <= '0;
      {n1v_q, n2v_q, dv_v_q} <= '0;
      rsp_valid_q <= 1'b0;
    end else if (en) begin
      v0_q  <= aim_req_i.valid;
      v1_q  <= v0_q;
      v2_q  <= v1_q;
      v3_q  <= v2_q;
      v4_q  <= v3_q;
      v5_q  <= v4_q;
      v6_q  <= v5_q;
      p1v_q <= sq1_end.v;
      p2v_q <= p1v_q;
      p3v_q <= p2v_q;
      p4v_q <= p3v_q;
      q1v_q <= p4v_q;
      q2v_q <= q1v_q;
      hv_q  <= q2v_q;
      n1v_q <= sq2_end.v;
      n2v_q <= n1v_q;
      dv_v_q <= n2v_q;
      rsp_valid_q <= div_end.v;
    end
  end

  // handshake
  assign en              = !rsp_valid_q || aim_rsp_o.ready;
  assign aim_req_i.ready = en;
  assign aim_rsp_o.valid = rsp_valid_q;
  assign aim_rsp_o.data  = rsp_q;

  // an unreachable target gives the zero vector
  a_unreach_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_q && !rsp_q.reachable |->
      (rsp_q.vel_x == '0) && (rsp_q.vel_y == '0) && (rsp_q.vel_z == '0))
    else $error("unreachable result with nonzero vector");

  // an empty output register never blocks requests
  a_free_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !rsp_valid_q |-> aim_req_i.ready)
    else $error("request blocked while output empty");

  // a result only appears from the end of the divider chain
  a_rsp_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(rsp_valid_q) |-> $past(div_end.v))
    else $error("result without a request in the chain");

endmodule
